// ===== sv/rlsg_pkg.sv =====
`default_nettype none
package rlsg_pkg;

   localparam int LINE_COUNT_DEFAULT = 224;

   localparam int CFG_INDEX_W = 2;
   localparam int CFG_ADDR_W  = CFG_INDEX_W + 2;
   localparam int CFG_DATA_W  = 32;

   localparam logic [CFG_INDEX_W-1:0] REG_HORIZON_LINE   = 2'd0;
   localparam logic [CFG_INDEX_W-1:0] REG_BASE_HSCROLL   = 2'd1;
   localparam logic [CFG_INDEX_W-1:0] REG_SKY_ZONE_END   = 2'd2;
   localparam logic [CFG_INDEX_W-1:0] REG_CLOUD_ZONE_END = 2'd3;

   localparam logic [7:0] HORIZON_LINE_RESET   = 8'd88;
   localparam logic [9:0] BASE_HSCROLL_RESET   = 10'h3A0;
   localparam logic [7:0] SKY_ZONE_END_RESET   = 8'd96;
   localparam logic [7:0] CLOUD_ZONE_END_RESET = 8'd144;

   localparam logic [5:0] CURVE_RISE_OFS = 6'd16;
   localparam logic [5:0] CURVE_FALL_OFS = 6'd48;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_LINE  = 1'b1;

   typedef struct packed {
      logic              func;
      logic [7:0]        frame_low;
      logic [7:0]        phase;
      logic signed [15:0] shake_x;
      logic signed [15:0] shake_y;
      logic              advance;
   } req_type;

   typedef struct packed {
      logic [7:0]         line_index;
      logic signed [15:0] plane_a_hscroll;
      logic signed [15:0] plane_b_hscroll;
      logic signed [15:0] plane_a_vscroll;
      logic signed [15:0] plane_b_vscroll;
      logic               last_line;
   } rsp_type;

   typedef struct packed {
      logic [7:0] horizon_line;
      logic [9:0] base_hscroll;
      logic [7:0] sky_zone_end;
      logic [7:0] cloud_zone_end;
   } cfg_type;

endpackage
`default_nettype wire

// ===== sv/rlsg_csr.sv =====
`default_nettype none
module rlsg_csr import rlsg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CFG_ADDR_W-1:0] paddr,
   input  wire logic [CFG_DATA_W-1:0] pwdata,
   output logic      [CFG_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [CFG_INDEX_W-1:0] index;
   logic wr_en;

   assign index  = paddr[CFG_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_HORIZON_LINE:   cfg_in.horizon_line   = pwdata[7:0];
            REG_BASE_HSCROLL:   cfg_in.base_hscroll   = pwdata[9:0];
            REG_SKY_ZONE_END:   cfg_in.sky_zone_end   = pwdata[7:0];
            REG_CLOUD_ZONE_END: cfg_in.cloud_zone_end = pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_HORIZON_LINE:   prdata = {24'd0, cfg_ff.horizon_line};
         REG_BASE_HSCROLL:   prdata = {22'd0, cfg_ff.base_hscroll};
         REG_SKY_ZONE_END:   prdata = {24'd0, cfg_ff.sky_zone_end};
         REG_CLOUD_ZONE_END: prdata = {24'd0, cfg_ff.cloud_zone_end};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.horizon_line   <= HORIZON_LINE_RESET;
         cfg_ff.base_hscroll   <= BASE_HSCROLL_RESET;
         cfg_ff.sky_zone_end   <= SKY_ZONE_END_RESET;
         cfg_ff.cloud_zone_end <= CLOUD_ZONE_END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rlsg_line_engine.sv =====
`default_nettype none
module rlsg_line_engine import rlsg_pkg::*; #(
   parameter int LINE_COUNT = LINE_COUNT_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_accept,
   input  wire req_type req_data,
   input  wire cfg_type cfg,
   output logic         push_valid,
   output rsp_type      push_data
);

   localparam int LC_W = $clog2(LINE_COUNT + 1);

   logic [LC_W-1:0] line_counter_ff, line_counter_in;
   logic [20:0]     bend_acc_ff, bend_acc_in;
   logic [14:0]     bend_step_ff, bend_step_in;
   logic [20:0]     streak_acc_ff, streak_acc_in;
   logic [5:0]      curve_ff, curve_in;
   logic [11:0]     streak_inc_ff, streak_inc_in;
   logic [15:0]     shake_x_ff, shake_x_in;
   logic [15:0]     shake_y_ff, shake_y_in;

   logic [5:0]  tri_val;
   logic [5:0]  new_curve;
   logic        skip;
   logic        active;
   logic        below_horizon;
   logic [15:0] base16, bend16, streak16, sx4, a_val, b_val;

   assign tri_val   = req_data.frame_low[7:2];
   assign new_curve = tri_val[5] ? 6'(CURVE_FALL_OFS - tri_val) : 6'(tri_val - CURVE_RISE_OFS);
   assign skip = req_data.advance & req_data.frame_low[0] &
                 (req_data.shake_x == 16'sd0) & (req_data.shake_y == 16'sd0);

   assign active        = 9'(line_counter_ff) < 9'(LINE_COUNT);
   assign below_horizon = 9'(line_counter_ff) >= 9'(cfg.horizon_line);

   assign base16   = {{6{cfg.base_hscroll[9]}}, cfg.base_hscroll};
   assign bend16   = {{9{bend_acc_ff[20]}}, bend_acc_ff[20:14]};
   assign streak16 = {3'd0, streak_acc_ff[20:8]};
   assign sx4      = {{2{shake_x_ff[15]}}, shake_x_ff[15:2]};

   always_comb begin
      if (below_horizon) begin
         a_val = base16 + bend16 - streak16 + shake_x_ff;
      end else begin
         a_val = base16 + shake_x_ff;
      end
      if (9'(line_counter_ff) < 9'(cfg.sky_zone_end)) begin
         b_val = base16 + sx4;
      end else if (9'(line_counter_ff) < 9'(cfg.cloud_zone_end)) begin
         b_val = base16 + {{13{curve_ff[5]}}, curve_ff[5:3]} + sx4;
      end else begin
         b_val = base16 - {{12{curve_ff[5]}}, curve_ff[5:2]} + sx4;
      end
   end

   assign push_valid                = req_accept & (req_data.func == FUNC_LINE) & active;
   assign push_data.line_index      = 8'(line_counter_ff);
   assign push_data.plane_a_hscroll = a_val;
   assign push_data.plane_b_hscroll = b_val;
   assign push_data.plane_a_vscroll = shake_y_ff - {6'd0, streak_inc_ff[11:2]};
   assign push_data.plane_b_vscroll = {{2{shake_y_ff[15]}}, shake_y_ff[15:2]};
   assign push_data.last_line       = line_counter_ff == LC_W'(LINE_COUNT - 1);

   always_comb begin
      line_counter_in = line_counter_ff;
      bend_acc_in     = bend_acc_ff;
      bend_step_in    = bend_step_ff;
      streak_acc_in   = streak_acc_ff;
      curve_in        = curve_ff;
      streak_inc_in   = streak_inc_ff;
      shake_x_in      = shake_x_ff;
      shake_y_in      = shake_y_ff;
      if (req_accept && req_data.func == FUNC_START) begin
         curve_in        = new_curve;
         streak_inc_in   = 12'(req_data.frame_low[4:1]) * 12'(req_data.phase);
         shake_x_in      = req_data.shake_x;
         shake_y_in      = req_data.shake_y;
         bend_acc_in     = '0;
         bend_step_in    = {{9{new_curve[5]}}, new_curve};
         streak_acc_in   = '0;
         line_counter_in = skip ? LC_W'(LINE_COUNT) : '0;
      end else if (push_valid) begin
         line_counter_in = line_counter_ff + 1'b1;
         if (below_horizon) begin
            bend_acc_in   = bend_acc_ff + {{6{bend_step_ff[14]}}, bend_step_ff};
            bend_step_in  = bend_step_ff + {{8{curve_ff[5]}}, curve_ff, 1'b0};
            streak_acc_in = streak_acc_ff + {9'd0, streak_inc_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_counter_ff <= LC_W'(LINE_COUNT);
         bend_acc_ff     <= '0;
         bend_step_ff    <= '0;
         streak_acc_ff   <= '0;
         curve_ff        <= '0;
         streak_inc_ff   <= '0;
         shake_x_ff      <= '0;
         shake_y_ff      <= '0;
      end else begin
         line_counter_ff <= line_counter_in;
         bend_acc_ff     <= bend_acc_in;
         bend_step_ff    <= bend_step_in;
         streak_acc_ff   <= streak_acc_in;
         curve_ff        <= curve_in;
         streak_inc_ff   <= streak_inc_in;
         shake_x_ff      <= shake_x_in;
         shake_y_ff      <= shake_y_in;
      end
   end

   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      9'(line_counter_ff) <= 9'(LINE_COUNT))
      else $error("line counter beyond line count");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> line_counter_ff == LC_W'($past(line_counter_ff) + 1'b1))
      else $error("line counter did not advance after a line word");

   a_start_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.func == FUNC_START && !skip) |=>
         (line_counter_ff == '0 && bend_acc_ff == '0 && streak_acc_ff == '0))
      else $error("start word did not restart the frame");

endmodule
`default_nettype wire

// ===== sv/rlsg_out_buf.sv =====
`default_nettype none
module rlsg_out_buf import rlsg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire rsp_type push_data,
   output logic         space,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop       = main_valid_ff & rsp_ready;
   assign space     = ~skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a main entry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push_valid)
      else $error("word pushed into a full buffer");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> (skid_valid_ff && $stable(skid_ff)))
      else $error("skid entry lost while stalled");

endmodule
`default_nettype wire

// ===== sv/road_line_scroll_generator.sv =====
// A line word's result is registered in the output buffer: main entry, or skid entry while main waits.
// Throughput: one word per cycle while req_ready is high; a start word gives no result.
// A two-entry output buffer keeps req_ready high while one result word waits on rsp_ready.
// Reset: synchronous, active high; registers return to their defaults, no frame active.
`default_nettype none
module road_line_scroll_generator import rlsg_pkg::*; #(
   parameter int LINE_COUNT = LINE_COUNT_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CFG_ADDR_W-1:0] paddr,
   input  wire logic [CFG_DATA_W-1:0] pwdata,
   output logic      [CFG_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type cfg;
   logic    req_accept;
   logic    push_valid;
   rsp_type push_data;
   logic    space;

   assign req_ready  = space;
   assign req_accept = req_valid & space;

   rlsg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rlsg_line_engine #(
      .LINE_COUNT (LINE_COUNT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rlsg_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .space      (space),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
